FILE: rtl/core/mdpf_pkg.sv
// Shared types and constants for the minimum-distance point filter.
`default_nettype none

package mdpf_pkg;

    // Coordinate width of one stored point axis
    localparam int COORD_W = 16;

    // Operation codes carried in the op field
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_TOO_CLOSE = 3'd1;
    localparam logic [2:0] ST_EXCLUDED  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DISABLED  = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE        = 2'd0;
    localparam logic [1:0] CFG_ALLOW_UWATER  = 2'd1;
    localparam logic [1:0] CFG_MIN_DISTANCE  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT_WINDOW = 2'd3;

    // Configuration reset values
    localparam logic        ENABLE_RST        = 1'b1;
    localparam logic        ALLOW_UWATER_RST  = 1'b0;
    localparam logic [15:0] MIN_DISTANCE_RST  = 16'd300;
    localparam logic [14:0] HEIGHT_WINDOW_RST = 15'd15;

    // Lift applied to candidate z
    localparam logic signed [16:0] Z_LIFT = 17'sd10;
    localparam logic signed [16:0] Z_MAX  = 17'sd32767;

    // Input word
    typedef struct packed {
        logic               op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               area_underwater;
        logic               area_blocked;
    } cand_t;

    // Output word
    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] node_count;
    } res_t;

    // One stored point
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    // Scan token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } scan_tok_t;

    // Store write request broadcast to the cells
    typedef struct packed {
        logic   we;
        point_t data;
    } store_wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/min_distance_point_filter_core.sv
// Top level of the minimum-distance point filter: sequencer, config and cell chain.
`default_nettype none

// Candidate points are checked against every stored point and appended when no
// stored point lies within min_distance (squared, in 3D) and the height window.
// The store is split round-robin over NUM_CELLS cells, each with its own RAM bank;
// a scan token walks the chain through the token registers of each cell while a new row
// enters the first cell each cycle. The input is stalled while an item is processed;
// a clear, disabled or excluded item skips the scan, as does an offer to an empty
// store, and other offers read the filled rows of each bank through its single read
// port. The store needs no clearing pass after reset: only entries below the fill
// count are compared.
// One result word is produced per input word; the output register lets the next
// word be accepted while the last result waits.
module min_distance_point_filter_core #(
    parameter int CAPACITY  = 1024,
    parameter int NUM_CELLS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cand_valid,
    output logic            cand_stall,
    input  mdpf_pkg::cand_t cand,
    output logic            res_valid,
    input  logic            res_stall,
    output mdpf_pkg::res_t  res,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    import mdpf_pkg::*;

    localparam int ROWS   = (CAPACITY + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ROWC_W = $clog2(ROWS + 1);
    localparam int BANK_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [BANK_W-1:0] LAST_BANK = BANK_W'(NUM_CELLS - 1);
    localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_WAIT,
        S_DECIDE,
        S_FINISH
    } state_t;

    // Configuration registers
    logic        enable_reg;
    logic        allow_uw_reg;
    logic [15:0] min_dist_reg;
    logic [14:0] height_win_reg;
    logic [31:0] lim_reg;

    // Sequencer state
    state_t            state_reg;
    cand_t             cand_reg;
    point_t            pt_reg;
    logic              hit_reg;
    logic [2:0]        status_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ROWC_W-1:0] fill_row_reg;
    logic [BANK_W-1:0] fill_bank_reg;
    logic [ROW_W-1:0]  scan_addr_reg;
    logic              res_valid_reg;
    res_t              res_reg;

    logic signed [16:0] z_lift;
    logic [ROW_W-1:0]   last_row;
    logic               scan_last;
    logic               excluded;
    store_wr_t          store_wr;

    scan_tok_t          tok_chain [NUM_CELLS + 1];
    logic [ROW_W-1:0]   addr_chain [NUM_CELLS + 1];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= ENABLE_RST;
            allow_uw_reg   <= ALLOW_UWATER_RST;
            min_dist_reg   <= MIN_DISTANCE_RST;
            height_win_reg <= HEIGHT_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:        enable_reg     <= cfg_data[0];
                CFG_ALLOW_UWATER:  allow_uw_reg   <= cfg_data[0];
                CFG_MIN_DISTANCE:  min_dist_reg   <= cfg_data;
                CFG_HEIGHT_WINDOW: height_win_reg <= cfg_data[14:0];
                default:           ;
            endcase
        end
    end

    // Squared distance limit, refreshed every cycle
    always_ff @(posedge clk)
    begin
        lim_reg <= 32'(min_dist_reg) * 32'(min_dist_reg);
    end

    // Saturating z lift
    always_comb
    begin
        z_lift = 17'(cand_reg.pos_z) + Z_LIFT;
        if (z_lift > Z_MAX)
        begin
            z_lift = Z_MAX;
        end
    end

    assign excluded = cand_reg.area_blocked || (cand_reg.area_underwater && !allow_uw_reg);

    // Final row to scan, from the fill position
    assign last_row  = (fill_bank_reg == '0) ? ROW_W'(fill_row_reg - 1'b1)
                                             : ROW_W'(fill_row_reg);
    assign scan_last = (scan_addr_reg == last_row);

    // Scan injection into the first cell
    assign tok_chain[0]  = '{valid: (state_reg == S_SCAN), last: scan_last, hit: 1'b0};
    assign addr_chain[0] = scan_addr_reg;

    // Append request
    always_comb
    begin
        store_wr.we   = (state_reg == S_DECIDE) && !hit_reg && (count_reg < CAP_CNT);
        store_wr.data = pt_reg;
    end

    // Cell chain
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        mdpf_cell #(
            .ROWS     (ROWS),
            .CELL_IDX (g),
            .BANK_W   (BANK_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_in        (tok_chain[g]),
            .addr_in       (addr_chain[g]),
            .cand_pt       (pt_reg),
            .lim           (lim_reg),
            .height_window (height_win_reg),
            .fill_row      (fill_row_reg),
            .fill_bank     (fill_bank_reg),
            .wr_bank       (fill_bank_reg),
            .store_wr      (store_wr),
            .tok_out       (tok_chain[g + 1]),
            .addr_out      (addr_chain[g + 1])
        );
    end

    // Sequencer with output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hit_reg       <= 1'b0;
            count_reg     <= '0;
            fill_row_reg  <= '0;
            fill_bank_reg <= '0;
            scan_addr_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // Result taken; a finishing item reloads it below instead
            if (res_valid_reg && !res_stall && (state_reg != S_FINISH))
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cand_valid)
                    begin
                        cand_reg  <= cand;
                        state_reg <= S_EVAL;
                    end
                end

                S_EVAL:
                begin
                    hit_reg <= 1'b0;
                    priority if (cand_reg.op == OP_CLEAR)
                    begin
                        count_reg     <= '0;
                        fill_row_reg  <= '0;
                        fill_bank_reg <= '0;
                        status_reg    <= ST_CLEARED;
                        state_reg     <= S_FINISH;
                    end
                    else if (!enable_reg)
                    begin
                        status_reg <= ST_DISABLED;
                        state_reg  <= S_FINISH;
                    end
                    else if (excluded)
                    begin
                        status_reg <= ST_EXCLUDED;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        pt_reg        <= '{x: cand_reg.pos_x, y: cand_reg.pos_y,
                                           z: z_lift[15:0]};
                        scan_addr_reg <= '0;
                        state_reg     <= (count_reg == '0) ? S_DECIDE : S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                    if (tok_chain[NUM_CELLS].valid && tok_chain[NUM_CELLS].hit)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (scan_last)
                    begin
                        state_reg <= S_WAIT;
                    end
                end

                S_WAIT:
                begin
                    if (tok_chain[NUM_CELLS].valid)
                    begin
                        if (tok_chain[NUM_CELLS].hit)
                        begin
                            hit_reg <= 1'b1;
                        end
                        if (tok_chain[NUM_CELLS].last)
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end

                S_DECIDE:
                begin
                    priority if (hit_reg)
                    begin
                        status_reg <= ST_TOO_CLOSE;
                    end
                    else if (count_reg >= CAP_CNT)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (fill_bank_reg == LAST_BANK)
                        begin
                            fill_bank_reg <= '0;
                            fill_row_reg  <= fill_row_reg + 1'b1;
                        end
                        else
                        begin
                            fill_bank_reg <= fill_bank_reg + 1'b1;
                        end
                        status_reg <= ST_ACCEPTED;
                    end
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg       <= '{status: status_reg, node_count: 11'(count_reg)};
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cand_stall = (state_reg != S_IDLE);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Fill count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("point count above capacity");

    // Append only happens with room in the store
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.we |-> (count_reg < CAP_CNT) && !hit_reg)
        else $error("store write without room or after a hit");

    // Scan tokens leave the chain only while a scan is in progress
    a_tok_window: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[NUM_CELLS].valid |-> (state_reg == S_SCAN || state_reg == S_WAIT))
        else $error("scan token outside a scan");

    // A new result word is loaded only after the old one is taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && res_valid_reg && res_stall) |=> $stable(res_reg))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: rtl/core/mdpf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mdpf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mdpf_cell.sv
// One scan cell: owns a bank of the point store and checks one row per cycle.
`default_nettype none

module mdpf_cell #(
    parameter int ROWS     = 256,
    parameter int CELL_IDX = 0,
    parameter int BANK_W   = 2,
    localparam int ROW_W   = $clog2(ROWS),
    localparam int ROWC_W  = $clog2(ROWS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mdpf_pkg::scan_tok_t       tok_in,
    input  logic [ROW_W-1:0]          addr_in,
    input  mdpf_pkg::point_t          cand_pt,
    input  logic [31:0]               lim,
    input  logic [14:0]               height_window,
    input  logic [ROWC_W-1:0]         fill_row,
    input  logic [BANK_W-1:0]         fill_bank,
    input  logic [BANK_W-1:0]         wr_bank,
    input  mdpf_pkg::store_wr_t       store_wr,
    output mdpf_pkg::scan_tok_t       tok_out,
    output logic [ROW_W-1:0]          addr_out
);

    import mdpf_pkg::*;

    localparam logic [BANK_W-1:0] MY_BANK = BANK_W'(CELL_IDX);

    // Stage registers: token and row travel alongside the data
    scan_tok_t        tok1_reg, tok2_reg, tok3_reg, tok4_reg;
    logic [ROW_W-1:0] addr1_reg, addr2_reg, addr3_reg, addr4_reg;

    logic             ent1_reg;
    logic             ent2_reg, hok2_reg;
    logic [15:0]      ax2_reg, ay2_reg, az2_reg;
    logic             ent3_reg, hok3_reg;
    logic [31:0]      sx3_reg, sy3_reg, sz3_reg;

    point_t           ent_pt;
    logic [POINT_W-1:0] rd_data;
    logic             ent_valid;

    logic signed [16:0] dx, dy, dz;
    logic [16:0]        adx, ady, adz;
    logic               hok;
    logic [33:0]        d2;
    logic               hit;

    // Bank storage for this cell
    mdpf_ram #(
        .WIDTH (POINT_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (store_wr.we && (wr_bank == MY_BANK)),
        .waddr (fill_row[ROW_W-1:0]),
        .wdata (store_wr.data),
        .raddr (addr_in),
        .rdata (rd_data)
    );

    assign ent_pt = point_t'(rd_data);

    // Entry holds a point when it lies below the fill position
    assign ent_valid = (ROWC_W'(addr_in) < fill_row) ||
                       ((ROWC_W'(addr_in) == fill_row) && (MY_BANK < fill_bank));

    // Differences and height window on the fetched entry
    always_comb
    begin
        dx  = 17'(cand_pt.x) - 17'(ent_pt.x);
        dy  = 17'(cand_pt.y) - 17'(ent_pt.y);
        dz  = 17'(cand_pt.z) - 17'(ent_pt.z);
        adx = dx[16] ? 17'(-dx) : 17'(dx);
        ady = dy[16] ? 17'(-dy) : 17'(dy);
        adz = dz[16] ? 17'(-dz) : 17'(dz);
        hok = (dz == 17'sd0) || (adz < {2'b00, height_window});
    end

    // Distance compare
    assign d2  = 34'(sx3_reg) + 34'(sy3_reg) + 34'(sz3_reg);
    assign hit = ent3_reg && hok3_reg && (d2 <= 34'(lim));

    // Token valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg <= '0;
            tok2_reg <= '0;
            tok3_reg <= '0;
            tok4_reg <= '0;
        end
        else
        begin
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
            tok3_reg <= tok2_reg;
            tok4_reg <= '{valid: tok3_reg.valid, last: tok3_reg.last,
                          hit: tok3_reg.hit | hit};
        end
    end

    // Data path
    always_ff @(posedge clk)
    begin
        addr1_reg <= addr_in;
        ent1_reg  <= ent_valid;

        addr2_reg <= addr1_reg;
        ent2_reg  <= ent1_reg;
        hok2_reg  <= hok;
        ax2_reg   <= adx[15:0];
        ay2_reg   <= ady[15:0];
        az2_reg   <= adz[15:0];

        addr3_reg <= addr2_reg;
        ent3_reg  <= ent2_reg;
        hok3_reg  <= hok2_reg;
        sx3_reg   <= 32'(ax2_reg) * 32'(ax2_reg);
        sy3_reg   <= 32'(ay2_reg) * 32'(ay2_reg);
        sz3_reg   <= 32'(az2_reg) * 32'(az2_reg);

        addr4_reg <= addr3_reg;
    end

    assign tok_out  = tok4_reg;
    assign addr_out = addr4_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_min_distance_point_filter_core.sv
// Testbench for the minimum-distance point filter core: directed cases, store fill, random phases.
`timescale 1ns / 1ps

module tb_min_distance_point_filter_core;
    import mdpf_pkg::*;

    localparam int CAPACITY      = 1024;
    localparam int MAX_GAP       = 14;
    // Worst offer is a full-store scan plus both sides' longest idle
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        cand_valid;
    logic        cand_stall;
    cand_t       cand;
    logic        res_valid;
    logic        res_stall;
    res_t        res;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Shadow of the register file
    logic        m_enable;
    logic        m_allow_uw;
    logic [15:0] m_min_dist;
    logic [14:0] m_hwin;

    // Shadow of the point store and the results still owed by the block
    point_t kept_pts [CAPACITY];
    int     kept_n;
    res_t   outcome_q [$];

    int fail_count   = 0;
    int quiet_cycles = 0;
    bit no_gaps      = 1'b0;

    min_distance_point_filter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .cand       (cand),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Idle cycles before the next word on either side
    function automatic int draw_gap();
        if (no_gaps)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic cand_t offer(int x, int y, int z, bit uw, bit blk);
        cand_t c;
        c.op              = OP_OFFER;
        c.pos_x           = clip16(x);
        c.pos_y           = clip16(y);
        c.pos_z           = clip16(z);
        c.area_underwater = uw;
        c.area_blocked    = blk;
        return c;
    endfunction

    function automatic cand_t clear_word();
        cand_t c;
        c    = '0;
        c.op = OP_CLEAR;
        return c;
    endfunction

    // True when some stored point lies inside the spacing sphere and height window
    function automatic bit near_stored_point(point_t p);
        longint lim;
        longint dx;
        longint dy;
        longint dz;
        longint d2;
        longint adz;
        lim = longint'(m_min_dist) * longint'(m_min_dist);
        for (int i = 0; i < kept_n; i++)
        begin
            dx  = longint'(p.x) - longint'(kept_pts[i].x);
            dy  = longint'(p.y) - longint'(kept_pts[i].y);
            dz  = longint'(p.z) - longint'(kept_pts[i].z);
            d2  = dx * dx + dy * dy + dz * dz;
            adz = (dz < 0) ? -dz : dz;
            if (d2 <= lim && (dz == 0 || adz < longint'(m_hwin)))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Outcome of one input word; updates the shadow store
    function automatic res_t place_point(cand_t c);
        res_t   r;
        point_t p;
        if (c.op == OP_CLEAR)
        begin
            kept_n   = 0;
            r.status = ST_CLEARED;
        end
        else if (!m_enable)
            r.status = ST_DISABLED;
        else if (c.area_blocked || (c.area_underwater && !m_allow_uw))
            r.status = ST_EXCLUDED;
        else
        begin
            p.x = c.pos_x;
            p.y = c.pos_y;
            p.z = clip16(int'(c.pos_z) + int'(Z_LIFT));
            if (near_stored_point(p))
                r.status = ST_TOO_CLOSE;
            else if (kept_n >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                kept_pts[kept_n] = p;
                kept_n++;
                r.status = ST_ACCEPTED;
            end
        end
        r.node_count = kept_n[10:0];
        return r;
    endfunction

    // Send one candidate word after a random gap and log its outcome
    task automatic send_word(cand_t c);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            cand_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cand       <= c;
        cand_valid <= 1'b1;
        do @(posedge clk); while (cand_stall);
        outcome_q.push_back(place_point(c));
    endtask

    // Stop sending and wait until every owed result has come back
    task automatic drain();
        @(negedge clk);
        cand_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:        m_enable   = val[0];
            CFG_ALLOW_UWATER:  m_allow_uw = val[0];
            CFG_MIN_DISTANCE:  m_min_dist = val;
            CFG_HEIGHT_WINDOW: m_hwin     = val[14:0];
            default: ;
        endcase
    endtask

    // Result side: random stall before each word
    initial
    begin : result_sink
        int gap;
        res_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    // Compare each result word with the oldest outcome owed
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("unexpected result word: status %0d node_count %0d",
                       res.status, res.node_count);
                fail_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    fail_count++;
                end
                if (res.node_count !== want.node_count)
                begin
                    $error("node_count: expected %0d, got %0d",
                           want.node_count, res.node_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (cand_valid && !cand_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Reset spacing of 300 and window of 15: boundaries in distance and height
    task automatic test_default_spacing();
        send_word(offer(0, 0, 0, 0, 0));
        send_word(offer(0, 0, 0, 0, 0));
        send_word(offer(300, 0, 0, 0, 0));
        send_word(offer(301, 0, 0, 0, 0));
        send_word(offer(0, 0, 14, 0, 0));
        send_word(offer(0, 0, 15, 0, 0));
        send_word(clear_word());
    endtask

    // Blocked always excluded, underwater only when not allowed
    task automatic test_area_flags();
        send_word(offer(10, 10, 0, 0, 1));
        send_word(offer(20, 20, 0, 1, 0));
        write_reg(CFG_ALLOW_UWATER, 16'd1);
        send_word(offer(20, 20, 0, 1, 0));
        send_word(offer(900, 900, 0, 1, 1));
        write_reg(CFG_ALLOW_UWATER, 16'd0);
    endtask

    // Disabled wins over area checks; clear still works
    task automatic test_disabled();
        write_reg(CFG_ENABLE, 16'd0);
        send_word(offer(-500, 40, 3, 0, 0));
        send_word(offer(-500, 40, 3, 1, 1));
        send_word(clear_word());
        write_reg(CFG_ENABLE, 16'd1);
    endtask

    // Coordinate corners, full spacing, z saturation, zero window and zero spacing
    task automatic test_coordinate_extremes();
        write_reg(CFG_MIN_DISTANCE, 16'hffff);
        write_reg(CFG_HEIGHT_WINDOW, 16'h7fff);
        send_word(offer(-32768, -32768, -32768, 0, 0));
        send_word(offer(32767, -32768, -32768, 0, 0));
        send_word(offer(32767, 32767, -32768, 0, 0));
        send_word(offer(0, 0, 32767, 0, 0));
        send_word(offer(0, 0, 32760, 0, 0));
        send_word(offer(0, 0, 32757, 0, 0));
        write_reg(CFG_HEIGHT_WINDOW, 16'd0);
        send_word(offer(0, 0, 32756, 0, 0));
        send_word(offer(1, 0, 32756, 0, 0));
        write_reg(CFG_MIN_DISTANCE, 16'd0);
        send_word(offer(0, 0, 32756, 0, 0));
        send_word(offer(5, 5, 32756, 0, 0));
        write_reg(CFG_MIN_DISTANCE, MIN_DISTANCE_RST);
        write_reg(CFG_HEIGHT_WINDOW, {1'b0, HEIGHT_WINDOW_RST});
    endtask

    // Fill the store to capacity, then hit the full and duplicate cases
    task automatic test_capacity();
        point_t first;
        write_reg(CFG_MIN_DISTANCE, 16'd0);
        write_reg(CFG_HEIGHT_WINDOW, 16'd0);
        send_word(clear_word());
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i % 128 == 0)
                no_gaps = ($urandom_range(0, 1) == 0);
            send_word(offer(i - 512, int'($urandom_range(0, 65535)) - 32768,
                            int'($urandom_range(0, 65535)) - 32768, 0, 0));
        end
        no_gaps = 1'b0;
        first = kept_pts[0];
        send_word(offer(600, 0, 0, 0, 0));
        send_word(offer(first.x, first.y, int'(first.z) - 10, 0, 0));
        send_word(offer(601, 0, 0, 0, 1));
        write_reg(CFG_ENABLE, 16'd0);
        send_word(offer(602, 0, 0, 0, 0));
        write_reg(CFG_ENABLE, 16'd1);
        send_word(clear_word());
        write_reg(CFG_MIN_DISTANCE, MIN_DISTANCE_RST);
        write_reg(CFG_HEIGHT_WINDOW, {1'b0, HEIGHT_WINDOW_RST});
    endtask

    function automatic logic [15:0] pick_distance();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd300;
            3:       return 16'hffff;
            4:       return 16'($urandom_range(2, 64));
            5:       return 16'($urandom_range(64, 4000));
            default: return 16'($urandom());
        endcase
    endfunction

    // Bit 15 of the data is random; the register keeps only 15 bits
    function automatic logic [15:0] pick_window();
        logic [15:0] top;
        top = {$urandom_range(0, 1) == 1, 15'd0};
        case ($urandom_range(0, 5))
            0:       return top | 16'd0;
            1:       return top | 16'd1;
            2:       return top | 16'd15;
            3:       return top | 16'h7fff;
            4:       return top | 16'($urandom_range(2, 60));
            default: return 16'($urandom());
        endcase
    endfunction

    // Mostly points near stored ones so spacing and window decide; some noise
    function automatic cand_t random_word();
        cand_t  c;
        point_t base;
        int     roll;
        int     span;
        int     zspan;
        roll              = $urandom_range(0, 99);
        c.op              = OP_OFFER;
        c.area_underwater = ($urandom_range(0, 5) == 0);
        c.area_blocked    = ($urandom_range(0, 9) == 0);
        if (roll < 3)
            c.op = OP_CLEAR;
        if (roll < 15 || kept_n == 0)
        begin
            c.pos_x = 16'($urandom());
            c.pos_y = 16'($urandom());
            c.pos_z = 16'($urandom());
        end
        else
        begin
            base  = kept_pts[$urandom_range(0, kept_n - 1)];
            span  = (m_min_dist > 2000) ? 2000 : int'(m_min_dist) + 1;
            zspan = (m_hwin > 40) ? 40 : int'(m_hwin) + 2;
            c.pos_x = clip16(int'(base.x) + int'($urandom_range(0, 2 * span)) - span);
            c.pos_y = clip16(int'(base.y) + int'($urandom_range(0, 2 * span)) - span);
            c.pos_z = clip16(int'(base.z) - 10 + int'($urandom_range(0, 2 * zspan)) - zspan);
        end
        return c;
    endfunction

    // Random phases, each under its own register setting
    task automatic test_random_fields();
        for (int phase = 0; phase < 10; phase++)
        begin
            write_reg(CFG_ENABLE, (phase < 2 || $urandom_range(0, 6) != 0) ? 16'd1 : 16'd0);
            write_reg(CFG_ALLOW_UWATER, 16'($urandom_range(0, 1)));
            if (phase == 0)
            begin
                write_reg(CFG_MIN_DISTANCE, 16'd0);
                write_reg(CFG_HEIGHT_WINDOW, 16'd0);
            end
            else if (phase == 1)
            begin
                write_reg(CFG_MIN_DISTANCE, 16'hffff);
                write_reg(CFG_HEIGHT_WINDOW, 16'hffff);
            end
            else
            begin
                write_reg(CFG_MIN_DISTANCE, pick_distance());
                write_reg(CFG_HEIGHT_WINDOW, pick_window());
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 58; k++)
            begin
                // hold the sender until the block has caught up
                if (phase == 3 && k == 29)
                    drain();
                send_word(random_word());
            end
            no_gaps = 1'b0;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cand_valid = 1'b0;
        cand       = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_ENABLE;
        cfg_data   = '0;
        m_enable   = ENABLE_RST;
        m_allow_uw = ALLOW_UWATER_RST;
        m_min_dist = MIN_DISTANCE_RST;
        m_hwin     = HEIGHT_WINDOW_RST;
        kept_n     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_spacing();
        test_area_flags();
        test_disabled();
        test_coordinate_extremes();
        test_capacity();
        test_random_fields();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outcome_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
